FILE: design/icef_pkg.sv
`default_nettype none
package icef_pkg;

	localparam int unsigned LINES = 32;

	// Item kinds.
	localparam logic [1:0] KIND_BUS  = 2'd0;
	localparam logic [1:0] KIND_PUSH = 2'd1;
	localparam logic [1:0] KIND_ACK  = 2'd2;
	localparam logic [1:0] KIND_WIRE = 2'd3;

	// Register selectors.
	localparam logic [3:0] SEL_MASK      = 4'd0;
	localparam logic [3:0] SEL_MASK_SET  = 4'd1;
	localparam logic [3:0] SEL_MASK_CLR  = 4'd2;
	localparam logic [3:0] SEL_STATUS    = 4'd3;
	localparam logic [3:0] SEL_STAT_SET  = 4'd4;
	localparam logic [3:0] SEL_STAT_CLR  = 4'd5;
	localparam logic [3:0] SEL_ACK       = 4'd6;
	localparam logic [3:0] SEL_ACK_SET   = 4'd7;
	localparam logic [3:0] SEL_ACK_CLR   = 4'd8;
	localparam logic [3:0] SEL_FIFO      = 4'd9;

	localparam logic [3:0] BUS_BYTES = 4'd4;

	// Signed 6-bit line code meaning no line.
	localparam logic [5:0] NO_IRQ = 6'h3f;

	// Highest set bit as a signed line code, NO_IRQ when the word is zero.
	function automatic logic [5:0] top_line(input logic [LINES-1:0] v);
		logic [5:0] r;
		r = NO_IRQ;
		for (int i = 0; i < LINES; i++) begin
			if (v[i]) begin
				r = 6'(i);
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: design/interrupt_controller_event_fifo.sv
`default_nettype none
// An item accepted into the input register has its result registered in the output
// register; while the output is stalled the item waits in the input register.
// Throughput: one item per cycle unless the output stalls; the FIFO head is read
// through a registered port whose address tracks the read pointer, forwarding a push to its slot.
// Reset (arst_n low) clears mask, status, ack, pointers, the reported line and the
// FIFO line register (disabled); the event storage holds no reset.
module interrupt_controller_event_fifo
	import icef_pkg::*;
#(
	parameter int unsigned FIFO_DEPTH = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [5:0]  cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  kind,
	input  wire logic [3:0]  reg_sel,
	input  wire logic        bus_write,
	input  wire logic [3:0]  access_bytes,
	input  wire logic [31:0] write_data,
	input  wire logic [7:0]  event_value,
	input  wire logic [4:0]  line,
	input  wire logic        line_active,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      read_data,
	output logic             resp_error,
	output logic             irq_pending,
	output logic [4:0]       irq_index,
	output logic             irq_update
);

	localparam int unsigned PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

	// Input register.
	logic        valid_s1;
	logic [1:0]  kind_s1;
	logic [3:0]  sel_s1;
	logic        wr_s1;
	logic [3:0]  bytes_s1;
	logic [31:0] data_s1;
	logic [7:0]  ev_s1;
	logic [4:0]  line_s1;
	logic        active_s1;

	// Controller state.
	logic [5:0]    fifo_line_q;
	logic [31:0]   mask_q;
	logic [31:0]   status_q;
	logic [31:0]   ack_q;
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] free_q;
	logic [5:0]    reported_q;
	logic [7:0]    head_q;
	logic [7:0]    store [FIFO_DEPTH];

	logic          advance;
	logic          work;
	logic [31:0]   mask_n;
	logic [31:0]   status_n;
	logic [31:0]   ack_n;
	logic [31:0]   rd_n;
	logic          err_n;
	logic          chk;
	logic          ack_chk;
	logic          push;
	logic          pop;
	logic          raise_en;
	logic [31:0]   raise_bit;
	logic [31:0]   line_bit;
	logic          setclr;
	logic [5:0]    top_n;
	logic          upd_n;
	logic [PW-1:0] rd_ptr_n;
	logic [PW-1:0] wr_ptr_inc;
	logic [PW-1:0] rd_ptr_inc;

	// The output register frees up when it is empty or being taken.
	assign advance  = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign work     = valid_s1 && advance;

	assign raise_en   = !fifo_line_q[5];
	assign raise_bit  = 32'(1) << fifo_line_q[4:0];
	assign line_bit   = 32'(1) << line_s1;
	assign setclr     = (sel_s1 == SEL_MASK_SET) || (sel_s1 == SEL_MASK_CLR) ||
	                    (sel_s1 == SEL_STAT_SET) || (sel_s1 == SEL_STAT_CLR) ||
	                    (sel_s1 == SEL_ACK_SET)  || (sel_s1 == SEL_ACK_CLR);
	assign wr_ptr_inc = (wr_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
	assign rd_ptr_inc = (rd_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);

	always_comb begin
		mask_n   = mask_q;
		status_n = status_q;
		ack_n    = ack_q;
		rd_n     = '0;
		err_n    = 1'b0;
		chk      = 1'b0;
		ack_chk  = 1'b0;
		push     = 1'b0;
		pop      = 1'b0;
		unique case (kind_s1)
			KIND_BUS: begin
				if (bytes_s1 != BUS_BYTES) begin
					err_n = 1'b1;
				end else if ((setclr && !wr_s1) || (sel_s1 == SEL_FIFO && wr_s1)) begin
					err_n = 1'b1;
				end else begin
					unique case (sel_s1)
						SEL_MASK: begin
							if (wr_s1) mask_n = data_s1;
							else rd_n = mask_q;
							chk = 1'b1;
						end
						SEL_MASK_SET: begin
							mask_n = mask_q | data_s1;
							chk    = 1'b1;
						end
						SEL_MASK_CLR: begin
							mask_n = mask_q & ~data_s1;
							chk    = 1'b1;
						end
						SEL_STATUS: begin
							if (wr_s1) begin
								status_n = data_s1;
								chk      = 1'b1;
							end else begin
								rd_n = status_q;
							end
						end
						SEL_STAT_SET: begin
							status_n = status_q | data_s1;
							chk      = 1'b1;
						end
						SEL_STAT_CLR: begin
							status_n = status_q & ~data_s1;
							chk      = 1'b1;
						end
						SEL_ACK: begin
							if (wr_s1) ack_n = data_s1;
							else rd_n = ack_q;
						end
						SEL_ACK_SET: ack_n = ack_q | data_s1;
						SEL_ACK_CLR: ack_n = ack_q & ~data_s1;
						SEL_FIFO: begin
							if (free_q != CW'(FIFO_DEPTH)) begin
								rd_n = 32'(head_q);
								pop  = 1'b1;
								// Events remain after this pop.
								if (free_q != CW'(FIFO_DEPTH - 1) && raise_en) begin
									status_n = status_q | raise_bit;
									chk      = 1'b1;
								end
							end
						end
						default: ;
					endcase
				end
			end
			KIND_PUSH: begin
				if (free_q != '0) begin
					push = 1'b1;
					if (free_q == CW'(FIFO_DEPTH) && raise_en) begin
						status_n = status_q | raise_bit;
						chk      = 1'b1;
					end
				end
			end
			KIND_ACK: begin
				status_n = status_q & ~line_bit;
				ack_n    = ack_q | line_bit;
				ack_chk  = 1'b1;
			end
			KIND_WIRE: begin
				if (active_s1) begin
					status_n = status_q | line_bit;
					chk      = 1'b1;
				end
			end
			default: ;
		endcase
		top_n = top_line(status_n & mask_n);
		// An acknowledge forgets the reported line, so any pending line is issued again.
		upd_n = (chk && (top_n != reported_q)) ||
		        (ack_chk && ((top_n != reported_q) || (top_n != NO_IRQ)));
		rd_ptr_n = (work && pop) ? rd_ptr_inc : rd_ptr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1   <= kind;
			sel_s1    <= reg_sel;
			wr_s1     <= bus_write;
			bytes_s1  <= access_bytes;
			data_s1   <= write_data;
			ev_s1     <= event_value;
			line_s1   <= line;
			active_s1 <= line_active;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fifo_line_q <= NO_IRQ;
			mask_q      <= '0;
			status_q    <= '0;
			ack_q       <= '0;
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			free_q      <= CW'(FIFO_DEPTH);
			reported_q  <= NO_IRQ;
		end else begin
			if (cfg_wr_en) begin
				fifo_line_q <= cfg_wr_data;
			end
			if (work) begin
				mask_q   <= mask_n;
				status_q <= status_n;
				ack_q    <= ack_n;
				rd_ptr_q <= rd_ptr_n;
				if (push) begin
					wr_ptr_q <= wr_ptr_inc;
					free_q   <= free_q - CW'(1);
				end else if (pop) begin
					free_q <= free_q + CW'(1);
				end
				if (chk || ack_chk) begin
					reported_q <= top_n;
				end
			end
		end
	end

	// Event storage; head_q always mirrors the entry at the read pointer.
	always_ff @(posedge clk) begin
		if (work && push) begin
			store[wr_ptr_q] <= ev_s1;
		end
		if (work && push && wr_ptr_q == rd_ptr_n) begin
			head_q <= ev_s1;
		end else begin
			head_q <= store[rd_ptr_n];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (work) begin
			read_data   <= rd_n;
			resp_error  <= err_n;
			irq_pending <= (top_n != NO_IRQ);
			irq_index   <= (top_n != NO_IRQ) ? top_n[4:0] : 5'd0;
			irq_update  <= upd_n;
		end
	end

endmodule
`default_nettype wire

FILE: verif/tb.sv
`default_nettype none
module tb;
	import icef_pkg::*;

	localparam int FIFO_DEPTH  = 8;
	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_HOLD   = 300;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  reg_sel;
		logic        bus_write;
		logic [3:0]  access_bytes;
		logic [31:0] write_data;
		logic [7:0]  event_value;
		logic [4:0]  line;
		logic        line_active;
	} irq_access_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        resp_error;
		logic        irq_pending;
		logic [4:0]  irq_index;
		logic        irq_update;
	} irq_response_t;

	// Tracks the controller state and the responses still owed by the block.
	class irq_response_board;
		logic signed [5:0] fifo_line;
		logic [31:0] mask_w;
		logic [31:0] status_w;
		logic [31:0] ack_w;
		logic [7:0]  fifo_mem [FIFO_DEPTH];
		int wr_ptr;
		int rd_ptr;
		int free_cnt;
		int shown_line;
		bit reissued;
		int errors;
		irq_response_t expected_responses[$];

		function new();
			fifo_line = 6'h3f;
			mask_w = '0;
			status_w = '0;
			ack_w = '0;
			foreach (fifo_mem[i]) fifo_mem[i] = '0;
			wr_ptr = 0;
			rd_ptr = 0;
			free_cnt = FIFO_DEPTH;
			shown_line = -1;
			reissued = 1'b0;
			errors = 0;
		endfunction

		function int highest_line(logic [31:0] v);
			for (int i = 31; i >= 0; i--) begin
				if (v[i]) return i;
			end
			return -1;
		endfunction

		function void recheck();
			int now;
			now = highest_line(status_w & mask_w);
			if (now != shown_line) begin
				shown_line = now;
				reissued = 1'b1;
			end
		endfunction

		function void put_status(logic [31:0] v);
			status_w = v;
			recheck();
		endfunction

		function void raise_fifo_line();
			if (fifo_line >= 0) begin
				put_status(status_w | (32'd1 << int'(fifo_line)));
			end
		endfunction

		function int outstanding();
			return expected_responses.size();
		endfunction

		function void predict_response(irq_access_t a);
			irq_response_t r;
			bit setclr;
			int top;
			r = '0;
			reissued = 1'b0;
			case (a.kind)
			KIND_BUS: begin
				setclr = a.reg_sel inside {SEL_MASK_SET, SEL_MASK_CLR, SEL_STAT_SET,
					SEL_STAT_CLR, SEL_ACK_SET, SEL_ACK_CLR};
				if (a.access_bytes != BUS_BYTES) begin
					r.resp_error = 1'b1;
				end else if (setclr && !a.bus_write) begin
					r.resp_error = 1'b1;
				end else if (a.reg_sel == SEL_FIFO && a.bus_write) begin
					r.resp_error = 1'b1;
				end else begin
					case (a.reg_sel)
					SEL_MASK: begin
						if (a.bus_write) mask_w = a.write_data;
						else r.read_data = mask_w;
						recheck();
					end
					SEL_MASK_SET: begin
						mask_w |= a.write_data;
						recheck();
					end
					SEL_MASK_CLR: begin
						mask_w &= ~a.write_data;
						recheck();
					end
					SEL_STATUS: begin
						if (a.bus_write) put_status(a.write_data);
						else r.read_data = status_w;
					end
					SEL_STAT_SET: put_status(status_w | a.write_data);
					SEL_STAT_CLR: put_status(status_w & ~a.write_data);
					SEL_ACK: begin
						if (a.bus_write) ack_w = a.write_data;
						else r.read_data = ack_w;
					end
					SEL_ACK_SET: ack_w |= a.write_data;
					SEL_ACK_CLR: ack_w &= ~a.write_data;
					SEL_FIFO: begin
						// A pop from an empty FIFO reads zero and leaves everything alone.
						if (free_cnt < FIFO_DEPTH) begin
							r.read_data = {24'd0, fifo_mem[rd_ptr]};
							rd_ptr = (rd_ptr + 1) % FIFO_DEPTH;
							free_cnt++;
							if (free_cnt != FIFO_DEPTH) raise_fifo_line();
						end
					end
					default: begin
					end
					endcase
				end
			end
			KIND_PUSH: begin
				if (free_cnt > 0) begin
					free_cnt--;
					fifo_mem[wr_ptr] = a.event_value;
					wr_ptr = (wr_ptr + 1) % FIFO_DEPTH;
					if (free_cnt == FIFO_DEPTH - 1) raise_fifo_line();
				end
			end
			KIND_ACK: begin
				put_status(status_w & ~(32'd1 << a.line));
				ack_w |= 32'd1 << a.line;
				shown_line = -1;
				recheck();
			end
			default: begin
				if (a.line_active) put_status(status_w | (32'd1 << a.line));
			end
			endcase
			top = highest_line(status_w & mask_w);
			r.irq_pending = (top >= 0);
			r.irq_index = (top >= 0) ? 5'(top) : 5'd0;
			r.irq_update = reissued;
			expected_responses.push_back(r);
		endfunction

		function void check_response(irq_response_t got);
			irq_response_t want;
			if (expected_responses.size() == 0) begin
				$error("response with nothing expected: %h", got);
				errors++;
				return;
			end
			want = expected_responses.pop_front();
			if (got.read_data !== want.read_data) begin
				$error("read_data: expected %h, actual %h", want.read_data, got.read_data);
				errors++;
			end
			if (got.resp_error !== want.resp_error) begin
				$error("resp_error: expected %b, actual %b", want.resp_error, got.resp_error);
				errors++;
			end
			if (got.irq_pending !== want.irq_pending) begin
				$error("irq_pending: expected %b, actual %b", want.irq_pending,
					got.irq_pending);
				errors++;
			end
			if (got.irq_index !== want.irq_index) begin
				$error("irq_index: expected %0d, actual %0d", want.irq_index, got.irq_index);
				errors++;
			end
			if (got.irq_update !== want.irq_update) begin
				$error("irq_update: expected %b, actual %b", want.irq_update, got.irq_update);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [5:0]  cfg_wr_data;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  kind;
	logic [3:0]  reg_sel;
	logic        bus_write;
	logic [3:0]  access_bytes;
	logic [31:0] write_data;
	logic [7:0]  event_value;
	logic [4:0]  line;
	logic        line_active;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] read_data;
	logic        resp_error;
	logic        irq_pending;
	logic [4:0]  irq_index;
	logic        irq_update;

	irq_response_board board = new();
	int send_gap_max = 6;
	int recv_gap_max = 6;
	bit hold_request = 1'b0;
	int quiet_cycles = 0;

	interrupt_controller_event_fifo #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.reg_sel(reg_sel),
		.bus_write(bus_write),
		.access_bytes(access_bytes),
		.write_data(write_data),
		.event_value(event_value),
		.line(line),
		.line_active(line_active),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_data(read_data),
		.resp_error(resp_error),
		.irq_pending(irq_pending),
		.irq_index(irq_index),
		.irq_update(irq_update)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic irq_access_t make_access(logic [1:0] k, logic [3:0] sel, logic wr,
			logic [3:0] bytes, logic [31:0] data, logic [7:0] ev, logic [4:0] ln,
			logic act);
		irq_access_t a;
		a.kind = k;
		a.reg_sel = sel;
		a.bus_write = wr;
		a.access_bytes = bytes;
		a.write_data = data;
		a.event_value = ev;
		a.line = ln;
		a.line_active = act;
		return a;
	endfunction

	// Mostly well-formed accesses, with a share of bad sizes, wrong directions and
	// unmapped selectors mixed in.
	function automatic irq_access_t random_access();
		irq_access_t a;
		int pick;
		int sel_pick;
		a.kind = 2'($urandom);
		a.reg_sel = 4'($urandom);
		a.bus_write = 1'($urandom);
		a.access_bytes = 4'($urandom);
		a.event_value = 8'($urandom);
		a.line = 5'($urandom);
		a.line_active = 1'($urandom);
		case ($urandom_range(0, 4))
		0: a.write_data = 32'd1 << a.line;
		1: a.write_data = '1;
		2: a.write_data = '0;
		default: a.write_data = $urandom;
		endcase
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			a.kind = KIND_BUS;
			if ($urandom_range(0, 9) != 0) a.access_bytes = BUS_BYTES;
			sel_pick = $urandom_range(0, 19);
			if (sel_pick < 5) a.reg_sel = SEL_FIFO;
			else if (sel_pick < 18) a.reg_sel = 4'($urandom_range(0, 8));
			if (a.reg_sel inside {SEL_MASK_SET, SEL_MASK_CLR, SEL_STAT_SET, SEL_STAT_CLR,
					SEL_ACK_SET, SEL_ACK_CLR}) begin
				a.bus_write = ($urandom_range(0, 7) != 0);
			end else if (a.reg_sel == SEL_FIFO) begin
				a.bus_write = ($urandom_range(0, 7) == 0);
			end
		end else if (pick < 67) begin
			a.kind = KIND_PUSH;
		end else if (pick < 80) begin
			a.kind = KIND_ACK;
		end else begin
			a.kind = KIND_WIRE;
			a.line_active = ($urandom_range(0, 4) != 0);
		end
		return a;
	endfunction

	task automatic drive_access(irq_access_t a);
		int gap;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= a.kind;
		reg_sel <= a.reg_sel;
		bus_write <= a.bus_write;
		access_bytes <= a.access_bytes;
		write_data <= a.write_data;
		event_value <= a.event_value;
		line <= a.line;
		line_active <= a.line_active;
		do @(posedge clk); while (in_stall !== 1'b0);
		board.predict_response(a);
	endtask

	// The register is only written once the block has drained.
	task automatic set_fifo_line(logic [5:0] v);
		in_valid <= 1'b0;
		while (board.outstanding() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		board.fifo_line = v;
	endtask

	task automatic run_phase(logic [5:0] cfg, int sgap, int rgap, int count, bit hold);
		set_fifo_line(cfg);
		send_gap_max = sgap;
		recv_gap_max = rgap;
		hold_request = hold;
		repeat (count) drive_access(random_access());
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		in_valid <= 1'b0;
		kind <= '0;
		reg_sel <= '0;
		bus_write <= 1'b0;
		access_bytes <= '0;
		write_data <= '0;
		event_value <= '0;
		line <= '0;
		line_active <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_fifo_line(6'd5);
		drive_access(make_access(KIND_BUS, SEL_MASK, 1, BUS_BYTES, 32'hffff_ffff, 0, 0, 0));
		drive_access(make_access(KIND_BUS, SEL_MASK, 0, BUS_BYTES, 0, 0, 0, 0));
		drive_access(make_access(KIND_BUS, SEL_MASK_CLR, 1, BUS_BYTES, 32'h0000_ffff, 0, 0, 0));
		drive_access(make_access(KIND_BUS, SEL_MASK_SET, 1, BUS_BYTES, 32'h0000_0021, 0, 0, 0));
		drive_access(make_access(KIND_WIRE, 0, 0, 0, 0, 0, 5'd31, 1));
		drive_access(make_access(KIND_WIRE, 0, 0, 0, 0, 0, 5'd3, 0));
		drive_access(make_access(KIND_BUS, SEL_STATUS, 0, BUS_BYTES, 0, 0, 0, 0));
		drive_access(make_access(KIND_BUS, SEL_STAT_SET, 1, BUS_BYTES, 32'h0001_0001, 0, 0, 0));
		drive_access(make_access(KIND_BUS, SEL_STAT_CLR, 1, BUS_BYTES, 32'h8000_0000, 0, 0, 0));
		drive_access(make_access(KIND_BUS, SEL_ACK, 1, BUS_BYTES, 32'hdead_beef, 0, 0, 0));
		drive_access(make_access(KIND_BUS, SEL_ACK_SET, 1, BUS_BYTES, 32'h0000_0010, 0, 0, 0));
		drive_access(make_access(KIND_BUS, SEL_ACK_CLR, 1, BUS_BYTES, 32'hffff_0000, 0, 0, 0));
		drive_access(make_access(KIND_ACK, 0, 0, 0, 0, 0, 5'd16, 0));
		drive_access(make_access(KIND_BUS, SEL_ACK, 0, BUS_BYTES, 0, 0, 0, 0));
		drive_access(make_access(KIND_BUS, SEL_MASK_SET, 0, BUS_BYTES, 0, 0, 0, 0));
		drive_access(make_access(KIND_BUS, SEL_FIFO, 1, BUS_BYTES, 32'h1234_5678, 0, 0, 0));
		drive_access(make_access(KIND_BUS, SEL_MASK, 1, 4'd8, 0, 0, 0, 0));
		drive_access(make_access(KIND_BUS, 4'd15, 1, BUS_BYTES, 32'hffff_ffff, 0, 0, 0));
		drive_access(make_access(KIND_BUS, SEL_STATUS, 1, BUS_BYTES, 0, 0, 0, 0));
		drive_access(make_access(KIND_BUS, SEL_FIFO, 0, BUS_BYTES, 0, 0, 0, 0));
		// Fill the FIFO and push once more, which must be dropped.
		for (int i = 0; i <= FIFO_DEPTH; i++) begin
			drive_access(make_access(KIND_PUSH, 0, 0, 0, 0, 8'(8'hff - i * 37), 0, 0));
		end
		drive_access(make_access(KIND_BUS, SEL_FIFO, 0, BUS_BYTES, 0, 0, 0, 0));
		drive_access(make_access(KIND_BUS, SEL_FIFO, 0, BUS_BYTES, 0, 0, 0, 0));

		run_phase(6'h3f, 6, 6, 125, 0);
		run_phase(6'd0, 0, 0, 125, 0);
		run_phase(6'd31, 6, 6, 125, 0);
		run_phase(6'h20, 0, 6, 125, 1);
		run_phase(6'($urandom_range(0, 31)), 6, 0, 125, 0);
		run_phase(6'($urandom_range(0, 63)), 0, 6, 125, 0);

		in_valid <= 1'b0;
		while (board.outstanding() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		if (board.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Response side: a random stall before each item, and one long hold-off on request.
	initial begin
		int stall_cycles;
		bit hold_taken;
		hold_taken = 1'b0;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall_cycles = $urandom_range(0, recv_gap_max);
			if (hold_request && !hold_taken) begin
				stall_cycles = LONG_HOLD;
				hold_taken = 1'b1;
			end
			if (stall_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (stall_cycles) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			board.check_response(irq_response_t'{read_data, resp_error, irq_pending,
				irq_index, irq_update});
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

endmodule
`default_nettype wire
